@@ hdl/lbc_pkg.sv @@
// ============================================================================
// lbc_pkg
// Shared codes and types of the LED blink controller: action codes of the
// input stream and the command that the top level hands to each channel.
// ============================================================================
package lbc_pkg;

    // Action codes carried in the input tuser field.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_REQUEST = 2'd1;
    localparam logic [1:0] ACT_RESTORE = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PRESENT = 1'b0;
    localparam logic CFG_ACTIVE  = 1'b1;

    // Byte-padded widths of the stream payloads.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int LEVEL_W     = 8;

    // Per-channel command for one advancing transaction.
    typedef struct packed {
        logic tick;         // advance the running timer
        logic request;      // new pattern addressed to this configured channel
        logic restore;      // reapply the saved pattern of this configured channel
        logic push;         // request saves the current pattern
        logic off_forever;  // request pattern stops after its first on pulse
    } t_chan_cmd;

endpackage

@@ hdl/lbc_chan.sv @@
// ============================================================================
// lbc_chan
// State and next-state logic of one LED channel: current and saved pattern,
// push slot, tick timer and lit flag.
// ============================================================================
module lbc_chan #(
    parameter int TIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  lbc_pkg::t_chan_cmd    i_cmd,
    input  logic [TIME_BITS-1:0]  i_on_time,
    input  logic [TIME_BITS-1:0]  i_off_time,
    output logic                  o_lit_next
);

    logic                 r_lit, n_lit;
    logic                 r_running, n_running;
    logic                 r_timer_made, n_timer_made;
    logic                 r_push_pending, n_push_pending;
    logic [TIME_BITS-1:0] r_remaining, n_remaining;
    logic [TIME_BITS-1:0] r_cur_on, n_cur_on;
    logic [TIME_BITS:0]   r_cur_off, n_cur_off;
    logic [TIME_BITS-1:0] r_saved_on, n_saved_on;
    logic [TIME_BITS:0]   r_saved_off, n_saved_off;

    logic                 w_apply;
    logic                 w_push;
    logic [TIME_BITS-1:0] w_on;
    logic [TIME_BITS:0]   w_off;

    // A restore replays the saved pattern as a push.
    assign w_apply = i_cmd.request | i_cmd.restore;
    assign w_push  = i_cmd.restore | i_cmd.push;
    assign w_on    = i_cmd.restore ? r_saved_on : i_on_time;
    assign w_off   = i_cmd.restore ? r_saved_off : {i_cmd.off_forever, i_off_time};

    always_comb begin
        n_lit          = r_lit;
        n_running      = r_running;
        n_timer_made   = r_timer_made;
        n_push_pending = r_push_pending;
        n_remaining    = r_remaining;
        n_cur_on       = r_cur_on;
        n_cur_off      = r_cur_off;
        n_saved_on     = r_saved_on;
        n_saved_off    = r_saved_off;

        if (w_apply) begin
            if (r_timer_made && !w_push && r_push_pending) begin
                // A push is pending: only the slot is overwritten.
                n_saved_on  = w_on;
                n_saved_off = w_off;
            end else begin
                if (r_timer_made) begin
                    n_running = 1'b0;
                end
                if (!r_push_pending) begin
                    n_saved_on     = r_cur_on;
                    n_saved_off    = r_cur_off;
                    n_push_pending = w_push;
                end
                n_cur_on  = w_on;
                n_cur_off = w_off;
                priority if (w_on == '0) begin
                    n_lit = 1'b0;
                end else if (w_off[TIME_BITS-1:0] == '0 && !w_off[TIME_BITS]) begin
                    n_lit = 1'b1;
                end else begin
                    n_timer_made = 1'b1;
                    n_lit        = 1'b1;
                    n_remaining  = w_on;
                    n_running    = 1'b1;
                end
            end
            if (i_cmd.restore) begin
                n_push_pending = 1'b0;
            end
        end else if (i_cmd.tick && r_running) begin
            if (r_remaining > TIME_BITS'(1)) begin
                n_remaining = r_remaining - TIME_BITS'(1);
            end else begin
                n_lit = !r_lit;
                if (r_lit && r_cur_off[TIME_BITS]) begin
                    // End of the single on pulse of a forever-off pattern.
                    n_running   = 1'b0;
                    n_remaining = '0;
                end else begin
                    n_remaining = r_lit ? r_cur_off[TIME_BITS-1:0] : r_cur_on;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit          <= 1'b0;
            r_running      <= 1'b0;
            r_timer_made   <= 1'b0;
            r_push_pending <= 1'b0;
            r_remaining    <= '0;
            r_cur_on       <= '0;
            r_cur_off      <= '0;
            r_saved_on     <= '0;
            r_saved_off    <= '0;
        end else if (i_advance) begin
            r_lit          <= n_lit;
            r_running      <= n_running;
            r_timer_made   <= n_timer_made;
            r_push_pending <= n_push_pending;
            r_remaining    <= n_remaining;
            r_cur_on       <= n_cur_on;
            r_cur_off      <= n_cur_off;
            r_saved_on     <= n_saved_on;
            r_saved_off    <= n_saved_off;
        end
    end

    assign o_lit_next = n_lit;

endmodule

@@ hdl/led_blink_controller_top.sv @@
// ============================================================================
// led_blink_controller_top
// LED blinker with per-channel tick timers, push/restore slot and
// configurable presence and active level masks.
// ============================================================================
// Usage:
//   Input stream (s_axis_*): one transaction per action. tuser holds the
//   action code (tick, blink request, restore); tdata holds the channel
//   index, on time, off time, forever-off flag and push flag.
//   Output stream (m_axis_*): exactly one transaction per input, in order;
//   tdata holds the pin level of every channel after that action, tuser
//   holds the ok flag (0 when a request or restore names an unconfigured
//   channel).
//   Configuration (i_cfg_*): index 0 writes the present mask, index 1 the
//   active level mask; always ready, to be written only while idle.
// Timing: an input is registered, then all channels update in parallel
//   into the output register; one transaction is accepted every cycle
//   while the receiver takes results. When the receiver stalls, the
//   output register holds its result and the input register fills; input
//   ready then drops until the output is taken.
// Reset: synchronous active low; all channels dark and stopped, present
//   mask 0, active level mask all ones, both stream registers empty.
// ============================================================================
module led_blink_controller_top #(
    parameter int LED_COUNT = 8,
    parameter int TIME_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: led_index[2:0], on_time[18:3], off_time[34:19], off_forever[35],
    //        is_push[36], zero[39:37]
    input  logic [lbc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]                          s_axis_tuser,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: led_levels[7:0]
    output logic [lbc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // tuser: ok[0]
    output logic [0:0]                          m_axis_tuser,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [lbc_pkg::LEVEL_W-1:0]         i_cfg_data
);

    localparam int EXT_W = (TIME_BITS > 16) ? TIME_BITS : 16;

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_action;
    logic [2:0]  r_index;
    logic [15:0] r_on_time;
    logic [15:0] r_off_time;
    logic        r_forever;
    logic        r_push;

    // Output register
    logic                        r_out_valid;
    logic [lbc_pkg::LEVEL_W-1:0] r_levels;
    logic                        r_ok;

    // Configuration registers
    logic [lbc_pkg::LEVEL_W-1:0] r_present;
    logic [lbc_pkg::LEVEL_W-1:0] r_active;

    logic                        w_advance;
    logic                        w_in_take;
    logic                        w_idx_present;
    logic                        w_is_cmd;
    logic                        n_ok;
    logic [lbc_pkg::LEVEL_W-1:0] n_levels;
    logic [EXT_W-1:0]            w_on_ext;
    logic [EXT_W-1:0]            w_off_ext;
    logic [TIME_BITS-1:0]        w_on;
    logic [TIME_BITS-1:0]        w_off;
    logic [LED_COUNT-1:0]        w_lit_next;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_action   <= s_axis_tuser;
            r_index    <= s_axis_tdata[2:0];
            r_on_time  <= s_axis_tdata[18:3];
            r_off_time <= s_axis_tdata[34:19];
            r_forever  <= s_axis_tdata[35];
            r_push     <= s_axis_tdata[36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_active  <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lbc_pkg::CFG_PRESENT: r_present <= i_cfg_data;
                lbc_pkg::CFG_ACTIVE:  r_active  <= i_cfg_data;
                default:              r_present <= r_present;
            endcase
        end
    end

    // Times are fitted to the timer width.
    assign w_on_ext  = EXT_W'(r_on_time);
    assign w_off_ext = EXT_W'(r_off_time);
    assign w_on      = w_on_ext[TIME_BITS-1:0];
    assign w_off     = w_off_ext[TIME_BITS-1:0];

    assign w_idx_present = (32'(r_index) < 32'(LED_COUNT)) && r_present[r_index];
    assign w_is_cmd      = (r_action == lbc_pkg::ACT_REQUEST) ||
                           (r_action == lbc_pkg::ACT_RESTORE);
    assign n_ok          = !w_is_cmd || w_idx_present;

    genvar c;
    generate
        for (c = 0; c < LED_COUNT; c++) begin : g_chan
            lbc_pkg::t_chan_cmd w_cmd;
            logic               w_sel;

            if (c < lbc_pkg::LEVEL_W) begin : g_addr
                assign w_sel = (r_index == 3'(c)) && r_present[c];
            end else begin : g_noaddr
                assign w_sel = 1'b0;
            end

            assign w_cmd.tick        = (r_action == lbc_pkg::ACT_TICK);
            assign w_cmd.request     = w_sel && (r_action == lbc_pkg::ACT_REQUEST);
            assign w_cmd.restore     = w_sel && (r_action == lbc_pkg::ACT_RESTORE);
            assign w_cmd.push        = r_push;
            assign w_cmd.off_forever = r_forever;

            lbc_chan #(
                .TIME_BITS (TIME_BITS)
            ) u_chan (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_advance  (w_advance),
                .i_cmd      (w_cmd),
                .i_on_time  (w_on),
                .i_off_time (w_off),
                .o_lit_next (w_lit_next[c])
            );
        end

        for (c = 0; c < lbc_pkg::LEVEL_W; c++) begin : g_level
            if (c < LED_COUNT) begin : g_on
                assign n_levels[c] = r_present[c] && (w_lit_next[c] == r_active[c]);
            end else begin : g_off
                assign n_levels[c] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_levels <= n_levels;
            r_ok     <= n_ok;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_levels;
    assign m_axis_tuser[0] = r_ok;

endmodule

@@ verif/tb_led_blink_controller_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_led_blink_controller_top
// Self-checking bench for the LED blink controller. A behavioral copy of the
// eight channel timers tracks every accepted action and predicts the pin
// levels and ok flag of its output transaction. Directed patterns come first,
// then random traffic over several mask settings and idle/stall mixes.
// ============================================================================
module tb_led_blink_controller_top;

    localparam int CLK_PERIOD    = 20;
    localparam int CHANNELS      = 8;
    localparam int TIME_W        = 16;
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 165;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct {
        logic [1:0]        action;
        logic [2:0]        chan;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic              off_forever;
        logic              push;
    } t_blink_cmd;

    typedef struct {
        logic [lbc_pkg::LEVEL_W-1:0] levels;
        logic                        ok;
    } t_pin_state;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = lbc_pkg::ACT_TICK;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic                            i_cfg_index = lbc_pkg::CFG_PRESENT;
    logic [lbc_pkg::LEVEL_W-1:0]     i_cfg_data = '0;

    // Behavioral copy of the blinker.
    logic [CHANNELS-1:0] present_mask;
    logic [CHANNELS-1:0] active_mask;
    logic [CHANNELS-1:0] lit;
    logic [CHANNELS-1:0] running;
    logic [CHANNELS-1:0] timer_made;
    logic [CHANNELS-1:0] push_pending;
    logic [TIME_W-1:0]   remaining [CHANNELS];
    logic [TIME_W-1:0]   cur_on    [CHANNELS];
    logic [TIME_W-1:0]   saved_on  [CHANNELS];
    logic [TIME_W:0]     cur_off   [CHANNELS];  // bit TIME_W is the forever flag
    logic [TIME_W:0]     saved_off [CHANNELS];

    t_pin_state expected_pins[$];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int error_count    = 0;

    led_blink_controller_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void reset_blinker();
        present_mask = '0;
        active_mask  = '1;
        lit          = '0;
        running      = '0;
        timer_made   = '0;
        push_pending = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            remaining[c] = '0;
            cur_on[c]    = '0;
            saved_on[c]  = '0;
            cur_off[c]   = '0;
            saved_off[c] = '0;
        end
    endfunction

    function automatic void load_pattern(int c, logic [TIME_W-1:0] on_t,
                                         logic [TIME_W:0] off_t, logic push);
        if (timer_made[c]) begin
            // A pending push absorbs normal requests into the saved slot.
            if (!push && push_pending[c]) begin
                saved_on[c]  = on_t;
                saved_off[c] = off_t;
                return;
            end
            running[c] = 1'b0;
        end
        if (!push_pending[c]) begin
            saved_on[c]     = cur_on[c];
            saved_off[c]    = cur_off[c];
            push_pending[c] = push;
        end
        cur_on[c]  = on_t;
        cur_off[c] = off_t;
        if (on_t == '0) begin
            lit[c] = 1'b0;
        end else if (off_t[TIME_W-1:0] == '0 && !off_t[TIME_W]) begin
            lit[c] = 1'b1;
        end else begin
            timer_made[c] = 1'b1;
            lit[c]        = 1'b1;
            remaining[c]  = on_t;
            running[c]    = 1'b1;
        end
    endfunction

    function automatic void tick_channels();
        for (int c = 0; c < CHANNELS; c++) begin
            if (running[c]) begin
                if (remaining[c] > 1) begin
                    remaining[c] = remaining[c] - 1'b1;
                end else begin
                    remaining[c] = '0;
                    lit[c] = !lit[c];
                    if (!lit[c] && cur_off[c][TIME_W]) begin
                        running[c] = 1'b0;
                    end else begin
                        remaining[c] = lit[c] ? cur_on[c] : cur_off[c][TIME_W-1:0];
                    end
                end
            end
        end
    endfunction

    function automatic t_pin_state predict_pins(t_blink_cmd cmd);
        t_pin_state res;
        res.ok = 1'b1;
        case (cmd.action)
            lbc_pkg::ACT_TICK: begin
                tick_channels();
            end
            lbc_pkg::ACT_REQUEST: begin
                if (present_mask[cmd.chan])
                    load_pattern(int'(cmd.chan), cmd.on_time,
                                 {cmd.off_forever, cmd.off_time}, cmd.push);
                else
                    res.ok = 1'b0;
            end
            lbc_pkg::ACT_RESTORE: begin
                if (present_mask[cmd.chan]) begin
                    load_pattern(int'(cmd.chan), saved_on[cmd.chan], saved_off[cmd.chan],
                                 1'b1);
                    push_pending[cmd.chan] = 1'b0;
                end else begin
                    res.ok = 1'b0;
                end
            end
            default: begin
            end
        endcase
        res.levels = present_mask & ~(lit ^ active_mask);
        return res;
    endfunction

    // Mostly short times so timers expire often; now and then a full-range value.
    function automatic logic [TIME_W-1:0] random_ticks();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return TIME_W'($urandom_range(0, 6));
        else if (pick < 90)
            return TIME_W'($urandom_range(0, 40));
        else
            return TIME_W'($urandom_range(0, 65535));
    endfunction

    function automatic t_blink_cmd random_cmd();
        t_blink_cmd cmd;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            cmd.action = lbc_pkg::ACT_TICK;
        else if (pick < 78)
            cmd.action = lbc_pkg::ACT_REQUEST;
        else if (pick < 95)
            cmd.action = lbc_pkg::ACT_RESTORE;
        else
            cmd.action = ACT_UNUSED;
        cmd.chan        = 3'($urandom_range(0, CHANNELS - 1));
        cmd.on_time     = random_ticks();
        cmd.off_time    = random_ticks();
        cmd.off_forever = ($urandom_range(0, 99) < 20);
        cmd.push        = ($urandom_range(0, 99) < 25);
        return cmd;
    endfunction

    task automatic send_cmd(input t_blink_cmd cmd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd.action;
        s_axis_tdata  <= {3'b000, cmd.push, cmd.off_forever, cmd.off_time, cmd.on_time,
                          cmd.chan};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_pins.push_back(predict_pins(cmd));
    endtask

    task automatic send_fields(input logic [1:0] action, input logic [2:0] chan,
                               input logic [TIME_W-1:0] on_t,
                               input logic [TIME_W-1:0] off_t,
                               input logic off_forever, input logic push);
        t_blink_cmd cmd;
        cmd.action      = action;
        cmd.chan        = chan;
        cmd.on_time     = on_t;
        cmd.off_time    = off_t;
        cmd.off_forever = off_forever;
        cmd.push        = push;
        send_cmd(cmd);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_fields(lbc_pkg::ACT_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
    endtask

    // Stops the input stream and waits until every result has been taken.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index,
                             input logic [lbc_pkg::LEVEL_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index == lbc_pkg::CFG_PRESENT)
            present_mask = value;
        else
            active_mask = value;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Nothing is configured after reset, so requests and restores fail.
    task automatic test_after_reset();
        set_idling(0, 0);
        send_ticks(1);
        send_fields(lbc_pkg::ACT_REQUEST, 3'd0, 16'd2, 16'd2, 1'b0, 1'b0);
        send_fields(lbc_pkg::ACT_RESTORE, 3'd3, '0, '0, 1'b0, 1'b0);
        send_fields(ACT_UNUSED, 3'd7, TIME_MAX, TIME_MAX, 1'b1, 1'b1);
    endtask

    task automatic test_patterns();
        write_reg(lbc_pkg::CFG_PRESENT, 8'hFF);
        write_reg(lbc_pkg::CFG_ACTIVE, 8'h5A);
        send_fields(lbc_pkg::ACT_REQUEST, 3'd0, 16'd0, 16'd5, 1'b0, 1'b0);  // solid off
        send_fields(lbc_pkg::ACT_REQUEST, 3'd1, 16'd3, 16'd0, 1'b0, 1'b0);  // solid on
        send_fields(lbc_pkg::ACT_REQUEST, 3'd2, 16'd1, 16'd2, 1'b0, 1'b0);
        send_fields(lbc_pkg::ACT_REQUEST, 3'd3, 16'd2, 16'd0, 1'b1, 1'b0);  // single pulse
        send_fields(lbc_pkg::ACT_REQUEST, 3'd4, 16'd1, 16'd4, 1'b1, 1'b0);
        send_fields(lbc_pkg::ACT_REQUEST, 3'd5, TIME_MAX, TIME_MAX, 1'b0, 1'b0);
        send_fields(lbc_pkg::ACT_REQUEST, 3'd6, TIME_MAX, 16'd0, 1'b0, 1'b0);
        send_ticks(3);
        send_fields(ACT_UNUSED, 3'd2, 16'd1, 16'd1, 1'b0, 1'b1);
        // Push a pattern, then a normal request only rewrites the saved slot.
        send_fields(lbc_pkg::ACT_REQUEST, 3'd2, 16'd2, 16'd1, 1'b0, 1'b1);
        send_fields(lbc_pkg::ACT_REQUEST, 3'd2, 16'd5, 16'd5, 1'b0, 1'b0);
        send_ticks(2);
        send_fields(lbc_pkg::ACT_RESTORE, 3'd2, '0, '0, 1'b0, 1'b0);
        send_fields(lbc_pkg::ACT_RESTORE, 3'd7, '0, '0, 1'b0, 1'b0);
        send_ticks(2);
    endtask

    // Dropping present bits hides channels whose timers keep running.
    task automatic test_unconfigured();
        write_reg(lbc_pkg::CFG_PRESENT, 8'h0F);
        write_reg(lbc_pkg::CFG_ACTIVE, 8'h00);
        send_fields(lbc_pkg::ACT_REQUEST, 3'd6, 16'd1, 16'd1, 1'b0, 1'b0);
        send_fields(lbc_pkg::ACT_RESTORE, 3'd5, '0, '0, 1'b0, 1'b0);
        send_ticks(2);
    endtask

    task automatic test_random_traffic();
        logic [lbc_pkg::LEVEL_W-1:0] present_set [RANDOM_PHASES] =
            '{8'hFF, 8'hFF, 8'hA5, 8'h7E, 8'hFF, 8'hF7, 8'hDB, 8'hFF};
        logic [lbc_pkg::LEVEL_W-1:0] active_set [RANDOM_PHASES] =
            '{8'hFF, 8'h00, 8'h5A, 8'hC3, 8'h0F, 8'hFF, 8'h24, 8'hAA};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(lbc_pkg::CFG_PRESENT, present_set[p]);
            write_reg(lbc_pkg::CFG_ACTIVE, active_set[p]);
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(73, 0);
                2: set_idling(0, 73);
                default: set_idling(20, 20);
            endcase
            repeat (PHASE_ITEMS) send_cmd(random_cmd());
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pin_state want;
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_pins.size());
            $display("** led_blink_controller_top: FAILED **");
            $finish;
        end else if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pins.size() == 0) begin
                $display("%0t: unexpected transaction, levels %02h ok %0b", $time,
                         m_axis_tdata, m_axis_tuser[0]);
                error_count = error_count + 1;
            end else begin
                want = expected_pins.pop_front();
                if (m_axis_tdata !== want.levels) begin
                    $display("%0t: led_levels expected %02h, actual %02h", $time,
                             want.levels, m_axis_tdata);
                    error_count = error_count + 1;
                end
                if (m_axis_tuser[0] !== want.ok) begin
                    $display("%0t: ok expected %0b, actual %0b", $time, want.ok,
                             m_axis_tuser[0]);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial begin
        reset_blinker();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_patterns();
        test_unconfigured();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("** led_blink_controller_top: PASSED **");
        else
            $display("** led_blink_controller_top: FAILED **");
        $finish;
    end

endmodule
